// ===== design/msp_enc_pkg.sv =====
`default_nettype none
package msp_enc_pkg;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_DATA  = 1'b1
	} item_kind_t;

	typedef enum logic {
		VER_1 = 1'b0,
		VER_2 = 1'b1
	} frame_ver_t;

	typedef struct packed {
		logic        kind;
		logic        version;
		logic [15:0] command;
		logic [15:0] length;
		logic [7:0]  payload;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} result_t;

	localparam logic [7:0] SYNC_CHAR = 8'h24;
	localparam logic [7:0] DIR_CHAR  = 8'h3E;
	localparam logic [7:0] V1_MARK   = 8'h4D;
	localparam logic [7:0] V2_MARK   = 8'h58;
	localparam logic [7:0] V2_FLAG   = 8'h00;
	localparam logic [7:0] CRC_POLY  = 8'hD5;

	localparam int unsigned IDX_W = 4;

	// byte positions within a start item
	localparam logic [IDX_W-1:0] POS_SYNC    = 4'd0;
	localparam logic [IDX_W-1:0] POS_MARK    = 4'd1;
	localparam logic [IDX_W-1:0] POS_DIR     = 4'd2;
	localparam logic [IDX_W-1:0] V1_POS_LEN  = 4'd3;
	localparam logic [IDX_W-1:0] V1_POS_CMD  = 4'd4;
	localparam logic [IDX_W-1:0] V1_POS_CHK  = 4'd5;
	localparam logic [IDX_W-1:0] V2_POS_FLAG = 4'd3;
	localparam logic [IDX_W-1:0] V2_POS_CL   = 4'd4;
	localparam logic [IDX_W-1:0] V2_POS_CH   = 4'd5;
	localparam logic [IDX_W-1:0] V2_POS_LL   = 4'd6;
	localparam logic [IDX_W-1:0] V2_POS_LH   = 4'd7;
	localparam logic [IDX_W-1:0] V2_POS_CHK  = 4'd8;

	// byte positions within a payload item
	localparam logic [IDX_W-1:0] POS_DATA     = 4'd0;
	localparam logic [IDX_W-1:0] POS_DATA_CHK = 4'd1;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] check_fold(input logic ver, input logic [7:0] acc,
		input logic [7:0] b);
		return (ver == VER_2) ? crc8_update(acc, b) : (acc ^ b);
	endfunction

endpackage
`default_nettype wire

// ===== design/msp_response_frame_encoder.sv =====
`default_nettype none
// path: the first byte of an item passes the item register, then the output register
// throughput: one frame byte per cycle unless the output stalls; a start item holds
// the sequencer for its header (+ check byte if the payload is empty), a payload item
// for its byte (+ check byte if last) or, outside a frame, for no byte; next item taken on last step
// reset: arst_n clears the valid flags, the sequencer and the frame state
module msp_response_frame_encoder (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire msp_enc_pkg::item_t    item,
	output logic                       tx_valid,
	input  wire logic                  tx_ready,
	output msp_enc_pkg::result_t       tx
);

	// item register and byte sequencer
	logic                           valid_s1;
	msp_enc_pkg::item_t             item_s1;
	logic [msp_enc_pkg::IDX_W-1:0]  idx_s1;

	// frame state
	logic        version_q;
	logic [15:0] left_q;
	logic [7:0]  accum_q;
	logic        in_frame_q;

	// output register
	logic                  out_valid_q;
	msp_enc_pkg::result_t  out_q;

	logic        emit;
	logic        last;
	logic        step;
	logic        out_space;
	logic [7:0]  byte_d;
	logic        end_d;
	logic        fold_en;
	logic [7:0]  fold_byte;
	logic        fold_ver;
	logic        hdr_end;
	logic        is_start;
	logic [15:0] len_eff;
	logic [msp_enc_pkg::IDX_W-1:0] chk_pos;

	assign is_start = (item_s1.kind == msp_enc_pkg::KIND_START);
	assign len_eff  = (item_s1.version == msp_enc_pkg::VER_2) ? item_s1.length
		: {8'd0, item_s1.length[7:0]};
	assign chk_pos  = (item_s1.version == msp_enc_pkg::VER_2) ? msp_enc_pkg::V2_POS_CHK
		: msp_enc_pkg::V1_POS_CHK;

	always_comb begin
		emit      = 1'b0;
		last      = 1'b0;
		byte_d    = 8'd0;
		end_d     = 1'b0;
		fold_en   = 1'b0;
		fold_byte = item_s1.payload;
		fold_ver  = version_q;
		hdr_end   = 1'b0;
		if (is_start) begin
			emit     = 1'b1;
			fold_ver = item_s1.version;
			hdr_end  = (idx_s1 == chk_pos - 4'd1);
			if (idx_s1 == chk_pos) begin
				byte_d = accum_q;
				end_d  = 1'b1;
				last   = 1'b1;
			end else begin
				last = hdr_end && (len_eff != 16'd0);
				if (item_s1.version == msp_enc_pkg::VER_2) begin
					unique case (idx_s1)
						msp_enc_pkg::POS_SYNC:    byte_d = msp_enc_pkg::SYNC_CHAR;
						msp_enc_pkg::POS_MARK:    byte_d = msp_enc_pkg::V2_MARK;
						msp_enc_pkg::POS_DIR:     byte_d = msp_enc_pkg::DIR_CHAR;
						msp_enc_pkg::V2_POS_FLAG: byte_d = msp_enc_pkg::V2_FLAG;
						msp_enc_pkg::V2_POS_CL:   byte_d = item_s1.command[7:0];
						msp_enc_pkg::V2_POS_CH:   byte_d = item_s1.command[15:8];
						msp_enc_pkg::V2_POS_LL:   byte_d = item_s1.length[7:0];
						msp_enc_pkg::V2_POS_LH:   byte_d = item_s1.length[15:8];
						default:                  byte_d = 8'd0;
					endcase
					// crc over the zero flag from a zero seed stays zero
					fold_en = (idx_s1 >= msp_enc_pkg::V2_POS_CL);
				end else begin
					unique case (idx_s1)
						msp_enc_pkg::POS_SYNC:   byte_d = msp_enc_pkg::SYNC_CHAR;
						msp_enc_pkg::POS_MARK:   byte_d = msp_enc_pkg::V1_MARK;
						msp_enc_pkg::POS_DIR:    byte_d = msp_enc_pkg::DIR_CHAR;
						msp_enc_pkg::V1_POS_LEN: byte_d = item_s1.length[7:0];
						msp_enc_pkg::V1_POS_CMD: byte_d = item_s1.command[7:0];
						default:                 byte_d = 8'd0;
					endcase
					fold_en = (idx_s1 >= msp_enc_pkg::V1_POS_LEN);
				end
				fold_byte = byte_d;
			end
		end else if (idx_s1 == msp_enc_pkg::POS_DATA_CHK) begin
			// check byte after the last payload byte, frame already closed
			emit   = 1'b1;
			byte_d = accum_q;
			end_d  = 1'b1;
			last   = 1'b1;
		end else if (!in_frame_q) begin
			// stray payload byte: retire with no output
			last = 1'b1;
		end else begin
			emit    = 1'b1;
			byte_d  = item_s1.payload;
			fold_en = 1'b1;
			last    = (left_q != 16'd1);
		end
	end

	assign out_space  = !out_valid_q || tx_ready;
	assign step       = valid_s1 && (!emit || out_space);
	assign item_ready = !valid_s1 || (step && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
		end else if (step) begin
			valid_s1 <= !last;
			idx_s1   <= idx_s1 + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q  <= 1'b0;
			left_q     <= 16'd0;
			accum_q    <= 8'd0;
			in_frame_q <= 1'b0;
		end else if (step) begin
			if (is_start) begin
				if (idx_s1 == msp_enc_pkg::POS_SYNC) begin
					version_q  <= item_s1.version;
					accum_q    <= 8'd0;
					in_frame_q <= 1'b0;
				end else if (fold_en) begin
					accum_q <= msp_enc_pkg::check_fold(fold_ver, accum_q, fold_byte);
				end
				if (hdr_end) begin
					left_q     <= len_eff;
					in_frame_q <= (len_eff != 16'd0);
				end
			end else if (in_frame_q && idx_s1 == msp_enc_pkg::POS_DATA) begin
				accum_q <= msp_enc_pkg::check_fold(fold_ver, accum_q, fold_byte);
				left_q  <= left_q - 16'd1;
				if (left_q == 16'd1) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_space) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_space && step && emit) begin
			out_q.out_byte  <= byte_d;
			out_q.frame_end <= end_d;
		end
	end

	assign tx_valid = out_valid_q;
	assign tx       = out_q;

endmodule
`default_nettype wire
